[src/wia_pkg.sv]
// ============================================================================
// wia_pkg
// Shared types, constants and mode codes for the 256-bit integer unit.
// ============================================================================
package wia_pkg;

    localparam int OPERAND_BITS_DEF = 256;
    localparam int WORD_BITS        = 64;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [3:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_SHL     = 4'd2,
        MODE_SAR     = 4'd3,
        MODE_LSR     = 4'd4,
        MODE_MUL     = 4'd5,
        MODE_DIV     = 4'd6,
        MODE_EQ      = 4'd7,
        MODE_LT      = 4'd8,
        MODE_STICKY  = 4'd9,
        MODE_INSERT  = 4'd10,
        MODE_EXTRACT = 4'd11
    } t_mode;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] a_word0;
        logic [63:0] a_word1;
        logic [63:0] a_word2;
        logic [63:0] a_word3;
        logic [63:0] b_word0;
        logic [63:0] b_word1;
        logic [63:0] b_word2;
        logic [63:0] b_word3;
        logic [8:0]  shift_amount;
        logic [7:0]  field_offset;
        logic [8:0]  field_width;
    } t_in;

    typedef struct packed {
        logic [63:0] res_word0;
        logic [63:0] res_word1;
        logic [63:0] res_word2;
        logic [63:0] res_word3;
        logic [63:0] rem_word0;
        logic [63:0] rem_word1;
        logic [63:0] rem_word2;
        logic [63:0] rem_word3;
        logic        flag;
    } t_out;

    // queue/back-end handshake
    typedef struct packed {
        logic valid;
        logic iter;   // multiply or divide: needs the iterative unit
    } t_qstat;

endpackage

[src/wide_integer_alu_256_core.sv]
// ============================================================================
// wide_integer_alu_256_core
// 256-bit integer unit: add/sub, shifts, multiply, divide, compare, fields.
// ============================================================================
// channel   | handshake             | payload
// item in   | start / busy          | i_item  (t_in)
// result    | o_done (one cycle)    | o_result (t_out)
//
// Simple modes: the item enters the queue; when the back end is idle it pops
// the item and registers the result. Multiply and divide: pop, operand prep,
// one operand bit per cycle in the shift/add-subtract loop, sign fix-up,
// output register. Sync active-low reset clears queue and sequencer. Up to
// two items queue while the back end works; busy rises when the queue is full.
module wide_integer_alu_256_core #(
    parameter int OPERAND_BITS = wia_pkg::OPERAND_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  wia_pkg::t_in   i_item,
    output logic           o_done,
    output wia_pkg::t_out  o_result
);
    import wia_pkg::*;

    t_qstat stat;
    t_in    q_item;
    logic   pop;

    wia_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_item, .o_full(busy),
        .i_pop(pop), .o_stat(stat), .o_item(q_item)
    );

    wia_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
        .i_clk, .i_rst_n, .i_stat(stat), .i_item(q_item), .o_pop(pop),
        .o_valid(o_done), .o_result
    );
endmodule

[src/wia_front.sv]
// ============================================================================
// wia_front
// Accepts items and classifies them; short queue toward the back end.
// ============================================================================
module wia_front #(
    parameter int OPERAND_BITS = wia_pkg::OPERAND_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  wia_pkg::t_in  i_item,
    output logic          o_full,
    input  logic          i_pop,
    output wia_pkg::t_qstat o_stat,
    output wia_pkg::t_in  o_item
);
    import wia_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_in              r_mem [QUEUE_DEPTH];
    logic             r_iter [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             push;

    assign o_full = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign push   = i_start && !o_full;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp]  <= i_item;
            r_iter[r_wp] <= (i_item.mode == MODE_MUL) || (i_item.mode == MODE_DIV);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_pop);
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.iter  = r_iter[r_rp];
endmodule

[src/wia_back.sv]
// ============================================================================
// wia_back
// Executes items: simple modes directly, multiply and divide one operand
// bit per cycle, divide with sign fix-up steps.
// ============================================================================
module wia_back #(
    parameter int OPERAND_BITS = wia_pkg::OPERAND_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wia_pkg::t_qstat i_stat,
    input  wia_pkg::t_in    i_item,
    output logic            o_pop,
    output logic            o_valid,
    output wia_pkg::t_out   o_result
);
    import wia_pkg::*;

    localparam int N  = OPERAND_BITS;
    localparam int CW = $clog2(N);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_LOOP, S_FIX, S_OUT} t_state;

    t_state         r_state;
    logic [N-1:0]   r_a, r_b, r_acc, r_q;
    logic [CW-1:0]  r_cnt;
    logic           r_div, r_sa, r_sq;
    logic           r_valid;
    t_out           r_res;

    logic [255:0]   a, b, simple_res, ins_mask, ins_val;
    logic           simple_flag;
    logic [N:0]     sum, diff, dd;
    logic [N-1:0]   rem_sh;
    logic [8:0]     amt;
    logic           sa, sbb;
    logic [255:0]   t;

    function automatic t_out pack_out(input logic [255:0] res, input logic [255:0] rem,
                                      input logic flag);
        t_out r;
        r.res_word0 = res[63:0];
        r.res_word1 = res[127:64];
        r.res_word2 = res[191:128];
        r.res_word3 = res[255:192];
        r.rem_word0 = rem[63:0];
        r.rem_word1 = rem[127:64];
        r.rem_word2 = rem[191:128];
        r.rem_word3 = rem[255:192];
        r.flag      = flag;
        return r;
    endfunction

    always_comb begin
        a = '0;
        b = '0;
        a[N-1:0] = N'({i_item.a_word3, i_item.a_word2, i_item.a_word1, i_item.a_word0});
        b[N-1:0] = N'({i_item.b_word3, i_item.b_word2, i_item.b_word1, i_item.b_word0});
        amt  = i_item.shift_amount;
        sa   = a[N-1];
        sbb  = b[N-1];
        sum  = {1'b0, a[N-1:0]} + {1'b0, b[N-1:0]};
        diff = {1'b0, a[N-1:0]} - {1'b0, b[N-1:0]};
        simple_res  = '0;
        simple_flag = 1'b0;
        ins_mask = '0;
        ins_val  = '0;
        t = '0;
        case (i_item.mode)
            MODE_ADD: begin
                simple_res[N-1:0] = sum[N-1:0];
                simple_flag = sum[N];
            end
            MODE_SUB: begin
                simple_res[N-1:0] = diff[N-1:0];
                simple_flag = diff[N];
            end
            MODE_SHL: if (amt < 9'(N)) simple_res[N-1:0] = a[N-1:0] << amt;
            MODE_SAR: begin
                if (amt < 9'(N)) simple_res[N-1:0] = N'($signed(a[N-1:0]) >>> amt);
                else simple_res[N-1:0] = {N{sa}};
            end
            MODE_LSR: if (amt < 9'(N)) simple_res[N-1:0] = a[N-1:0] >> amt;
            MODE_EQ:  simple_flag = (a == b);
            MODE_LT:  simple_flag = (sa != sbb) ? sa : diff[N];
            MODE_STICKY: begin
                if (amt >= 9'(N)) simple_flag = |a;
                else simple_flag = |(a & ~({256{1'b1}} << amt));
            end
            MODE_INSERT: begin
                if (i_item.field_width >= 9'd256) ins_mask = {256{1'b1}};
                else ins_mask = ~({256{1'b1}} << i_item.field_width);
                ins_mask = ins_mask << i_item.field_offset;
                ins_val  = b << i_item.field_offset;
                simple_res = (a & ~ins_mask) | (ins_val & ins_mask);
                simple_res[255:0] = simple_res & ({256{1'b1}} >> (256 - N));
            end
            MODE_EXTRACT: begin
                t = a >> i_item.field_offset;
                if (i_item.field_width == 9'd0) simple_res[63:0] = '0;
                else if (i_item.field_width < 9'd64)
                    simple_res[63:0] = t[63:0] & ~({64{1'b1}} << i_item.field_width[5:0]);
                else simple_res[63:0] = t[63:0];
            end
            default: ;
        endcase
    end

    // iterative datapath step
    always_comb begin
        rem_sh = {r_acc[N-2:0], r_a[N-1]};
        dd     = {1'b0, rem_sh} - {1'b0, r_b};
    end

    assign o_pop = (r_state == S_IDLE) && i_stat.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_stat.valid) begin
                    if (i_stat.iter) begin
                        r_state <= S_PREP;
                    end else begin
                        r_valid <= 1'b1;
                    end
                end
                S_PREP: r_state <= S_LOOP;
                S_LOOP: if (r_cnt == '0) r_state <= S_FIX;
                S_FIX:  r_state <= S_OUT;
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_stat.valid) begin
                r_res <= pack_out(simple_res, '0, simple_flag);
                r_a   <= a[N-1:0];
                r_b   <= b[N-1:0];
                r_div <= (i_item.mode == MODE_DIV);
                r_sa  <= sa;
                r_sq  <= sa ^ sbb;
            end
            S_PREP: begin
                r_acc <= '0;
                r_q   <= '0;
                r_cnt <= CW'(N - 1);
                if (r_div) begin
                    if (r_sa) r_a <= -r_a;
                    if (r_b[N-1]) r_b <= -r_b;
                end
            end
            S_LOOP: begin
                r_cnt <= r_cnt - 1'b1;
                r_a   <= r_a << 1;
                if (r_div) begin
                    if (!dd[N]) begin
                        r_acc <= dd[N-1:0];
                        r_q   <= {r_q[N-2:0], 1'b1};
                    end else begin
                        r_acc <= rem_sh;
                        r_q   <= {r_q[N-2:0], 1'b0};
                    end
                end else begin
                    r_acc <= (r_acc << 1) + (r_a[N-1] ? r_b : '0);
                end
            end
            S_FIX: begin
                if (r_div) begin
                    if (r_sq) r_q <= -r_q;
                    if (r_sa) r_acc <= -r_acc;
                end
            end
            S_OUT: begin
                if (r_div) begin
                    r_res <= pack_out(256'(r_q), 256'(r_acc), 1'b0);
                end else begin
                    r_res <= pack_out(256'(r_acc), '0, 1'b0);
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;
endmodule

[src/wia_checker.sv]
// ============================================================================
// wia_checker
// Port-level checks for the 256-bit integer unit.
// ============================================================================
module wia_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input wia_pkg::t_in  i_item,
    input logic          o_done,
    input wia_pkg::t_out o_result
);
    import wia_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_done && !busy)
        else $error("activity after reset");
    a_no_spur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_done) else $error("result without item");
    a_busy_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(busy) && !$isunknown(o_done)) else $error("unknown handshake");
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_result)) else $error("unknown result");
endmodule

bind wide_integer_alu_256_core wia_checker u_chk (.*);

[tb/wide_integer_alu_256_checker.sv]
// ============================================================================
// wide_integer_alu_256_checker
// Watches the item and result channels of the 256-bit integer unit, works out
// each expected result from the accepted item and compares it, field by
// field, with the result that the unit strobes out.
// ============================================================================
module wide_integer_alu_256_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  wia_pkg::t_in  i_item,
    input  logic          i_done,
    input  wia_pkg::t_out i_result,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wia_pkg::*;

    localparam int NB = 256;

    t_out expected_results[$];
    int   fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic logic [NB-1:0] negate(input logic [NB-1:0] x);
        return ~x + 1'b1;
    endfunction

    function automatic t_out alu_result(input t_in it);
        logic [NB-1:0] a, b, res, rem, mask, ma, mb, t;
        logic [NB:0]   wide_sum;
        logic          flag, sa, sbt;
        int            amt, off, wid;
        t_out          r;
        a   = {it.a_word3, it.a_word2, it.a_word1, it.a_word0};
        b   = {it.b_word3, it.b_word2, it.b_word1, it.b_word0};
        amt = it.shift_amount;
        off = it.field_offset;
        wid = it.field_width;
        res = '0;
        rem = '0;
        flag = 1'b0;
        sa  = a[NB-1];
        sbt = b[NB-1];
        case (it.mode)
            MODE_ADD: begin
                wide_sum = {1'b0, a} + {1'b0, b};
                res = wide_sum[NB-1:0];
                flag = wide_sum[NB];
            end
            MODE_SUB: begin
                res = a - b;
                flag = a < b;
            end
            MODE_SHL: res = (amt >= NB) ? '0 : a << amt;
            MODE_SAR: res = (amt >= NB) ? {NB{sa}} : NB'($signed(a) >>> amt);
            MODE_LSR: res = (amt >= NB) ? '0 : a >> amt;
            MODE_MUL: res = a * b;
            MODE_DIV: begin
                ma = sa ? negate(a) : a;
                mb = sbt ? negate(b) : b;
                if (mb == '0) begin
                    res = '1;
                    rem = ma;
                end else begin
                    res = ma / mb;
                    rem = ma % mb;
                end
                if (sa ^ sbt) res = negate(res);
                if (sa) rem = negate(rem);
            end
            MODE_EQ: flag = (a == b);
            MODE_LT: flag = $signed(a) < $signed(b);
            MODE_STICKY: begin
                mask = (amt >= NB) ? '1 : (NB'(1) << amt) - 1'b1;
                flag = |(a & mask);
            end
            MODE_INSERT: begin
                mask = (wid >= NB) ? '1 : (NB'(1) << wid) - 1'b1;
                res = (a & ~(mask << off)) | ((b & mask) << off);
            end
            MODE_EXTRACT: begin
                t = a >> off;
                res[63:0] = t[63:0];
                if (wid == 0) res[63:0] = '0;
                else if (wid < 64) res[63:0] = t[63:0] & ((64'd1 << wid) - 1'b1);
            end
            default: ;
        endcase
        r.res_word0 = res[63:0];
        r.res_word1 = res[127:64];
        r.res_word2 = res[191:128];
        r.res_word3 = res[255:192];
        r.rem_word0 = rem[63:0];
        r.rem_word1 = rem[127:64];
        r.rem_word2 = rem[191:128];
        r.rem_word3 = rem[255:192];
        r.flag      = flag;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        fail_count++;
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_start && !i_busy) expected_results.push_back(alu_result(i_item));
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report("unexpected transaction", 64'd0, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.res_word0 !== want.res_word0)
                        report("res_word0", i_result.res_word0, want.res_word0);
                    if (i_result.res_word1 !== want.res_word1)
                        report("res_word1", i_result.res_word1, want.res_word1);
                    if (i_result.res_word2 !== want.res_word2)
                        report("res_word2", i_result.res_word2, want.res_word2);
                    if (i_result.res_word3 !== want.res_word3)
                        report("res_word3", i_result.res_word3, want.res_word3);
                    if (i_result.rem_word0 !== want.rem_word0)
                        report("rem_word0", i_result.rem_word0, want.rem_word0);
                    if (i_result.rem_word1 !== want.rem_word1)
                        report("rem_word1", i_result.rem_word1, want.rem_word1);
                    if (i_result.rem_word2 !== want.rem_word2)
                        report("rem_word2", i_result.rem_word2, want.rem_word2);
                    if (i_result.rem_word3 !== want.rem_word3)
                        report("rem_word3", i_result.rem_word3, want.rem_word3);
                    if (i_result.flag !== want.flag)
                        report("flag", 64'(i_result.flag), 64'(want.flag));
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
// ============================================================================
// testbench
// Drives directed and random transactions with random gaps into the 256-bit
// integer unit; the checker predicts and compares every result.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wia_pkg::*;

    localparam int N_RANDOM  = 1630;
    localparam int IDLE_LIMIT = 5000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_in   i_item = '0;
    logic  o_done;
    t_out  o_result;
    int    fail_count, pending;
    int    idle_cycles = 0;

    wide_integer_alu_256_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    wide_integer_alu_256_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_done      (o_done),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("** wide_integer_alu_256_core: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [255:0] rand_operand();
        logic [255:0] v;
        v = {rand_word(), rand_word(), rand_word(), rand_word()};
        case ($urandom_range(0, 5))
            0: v = 256'($urandom_range(0, 1000));
            1: v = -256'($urandom_range(1, 1000));
            2: v = v >> $urandom_range(0, 255);
            3: v = $signed(v) >>> $urandom_range(0, 255);
            default: ;
        endcase
        return v;
    endfunction

    function automatic int rand_count();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 256;
            2: return $urandom_range(0, 511);
            3: return $urandom_range(0, 64);
            default: return $urandom_range(0, 256);
        endcase
    endfunction

    function automatic t_in make_item(input logic [3:0] mode, input logic [255:0] a,
                                      input logic [255:0] b, input int amt,
                                      input int off, input int wid);
        t_in it;
        it.mode = mode;
        {it.a_word3, it.a_word2, it.a_word1, it.a_word0} = a;
        {it.b_word3, it.b_word2, it.b_word1, it.b_word0} = b;
        it.shift_amount = 9'(amt);
        it.field_offset = 8'(off);
        it.field_width  = 9'(wid);
        return it;
    endfunction

    // holds start high until the transaction is taken, then maybe idles
    task automatic send(input t_in it);
        int gap;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            9: gap = $urandom_range(10, 40);
            default: gap = $urandom_range(1, 4);
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    localparam logic [255:0] MIN_VAL = {1'b1, 255'd0};
    localparam logic [255:0] MAX_VAL = {1'b0, {255{1'b1}}};
    localparam logic [255:0] ONES    = '1;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(make_item(MODE_ADD, ONES, 256'd1, 0, 0, 0));
        send(make_item(MODE_ADD, MAX_VAL, MAX_VAL, 511, 255, 511));
        send(make_item(MODE_SUB, 256'd0, 256'd1, 0, 0, 0));
        send(make_item(MODE_SUB, MIN_VAL, MAX_VAL, 0, 0, 0));
        send(make_item(MODE_SHL, ONES, '0, 256, 0, 0));
        send(make_item(MODE_SHL, ONES, '0, 255, 0, 0));
        send(make_item(MODE_SAR, MIN_VAL, '0, 256, 0, 0));
        send(make_item(MODE_SAR, MIN_VAL, '0, 300, 0, 0));
        send(make_item(MODE_LSR, ONES, '0, 256, 0, 0));
        send(make_item(MODE_MUL, MIN_VAL, ONES, 0, 0, 0));
        send(make_item(MODE_MUL, MAX_VAL, MAX_VAL, 0, 0, 0));
        send(make_item(MODE_DIV, MIN_VAL, ONES, 0, 0, 0));
        send(make_item(MODE_DIV, 256'd12345, '0, 0, 0, 0));
        send(make_item(MODE_DIV, -256'd12345, '0, 0, 0, 0));
        send(make_item(MODE_DIV, -256'd7, 256'd2, 0, 0, 0));
        send(make_item(MODE_EQ, ONES, ONES, 0, 0, 0));
        send(make_item(MODE_LT, MIN_VAL, MAX_VAL, 0, 0, 0));
        send(make_item(MODE_LT, MAX_VAL, MIN_VAL, 0, 0, 0));
        send(make_item(MODE_STICKY, MIN_VAL, '0, 256, 0, 0));
        send(make_item(MODE_STICKY, MIN_VAL, '0, 255, 0, 0));
        send(make_item(MODE_INSERT, ONES, '0, 0, 200, 0));
        send(make_item(MODE_INSERT, '0, ONES, 0, 255, 256));
        send(make_item(MODE_EXTRACT, ONES, '0, 0, 255, 0));
        send(make_item(MODE_EXTRACT, ONES, '0, 0, 3, 511));
        send(make_item(4'd15, ONES, ONES, 511, 255, 511));

        for (int n = 0; n < N_RANDOM; n++) begin
            logic [255:0] a, b;
            a = rand_operand();
            b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
            send(make_item(4'($urandom_range(0, 15)), a, b, rand_count(),
                           $urandom_range(0, 255), rand_count()));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** wide_integer_alu_256_core: PASSED **");
        end else begin
            $display("** wide_integer_alu_256_core: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
src/wia_pkg.sv
src/wia_front.sv
src/wia_back.sv
src/wide_integer_alu_256_core.sv
src/wia_checker.sv
tb/wide_integer_alu_256_checker.sv
tb/testbench.sv
